[rtl/core/pidc_pkg.sv]
// Shared constants, register indexes and saturation helpers for the PID controller.
// Used by the channel interfaces, the serial divider and the top level.
package pidc_pkg;

    localparam int DATA_W     = 32;             // Q16.16 data width
    localparam int LIM_W      = 31;             // integral limit width
    localparam int WIDE_W     = DATA_W + 1;     // operand and difference width
    localparam int PROD_W     = 2 * WIDE_W;     // full product width
    localparam int FRAC_W     = 16;             // fraction bits
    localparam int SUM_W      = DATA_W + 3;     // room for three saturated terms
    localparam int DIVD_W     = WIDE_W + FRAC_W; // |diff| shifted up by the fraction
    localparam int DIV_CNT_W  = $clog2(DIVD_W + 1);
    localparam int CFG_IDX_W  = 3;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_PROP_GAIN   = 3'd0;
    localparam cfg_idx_t REG_INTEG_GAIN  = 3'd1;
    localparam cfg_idx_t REG_DERIV_GAIN  = 3'd2;
    localparam cfg_idx_t REG_SETPOINT    = 3'd3;
    localparam cfg_idx_t REG_OUT_MIN     = 3'd4;
    localparam cfg_idx_t REG_OUT_MAX     = 3'd5;
    localparam cfg_idx_t REG_INTEG_LIMIT = 3'd6;

    localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    localparam logic signed [DATA_W-1:0] PROP_GAIN_RST   = 32'sd32768;
    localparam logic signed [DATA_W-1:0] INTEG_GAIN_RST  = 32'sd13107;
    localparam logic [LIM_W-1:0]         INTEG_LIMIT_RST = 31'd131072;

    // Saturate a 33-bit sum or difference to the signed 32-bit range.
    function automatic logic signed [DATA_W-1:0] sat_wide(input logic signed [WIDE_W-1:0] v);
        if (v[WIDE_W-1] != v[WIDE_W-2])
            return v[WIDE_W-1] ? Q_MIN : Q_MAX;
        return v[DATA_W-1:0];
    endfunction

    // Saturate the running sum of product terms.
    function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
        if (v > SUM_W'(Q_MAX))
            return Q_MAX;
        if (v < SUM_W'(Q_MIN))
            return Q_MIN;
        return v[DATA_W-1:0];
    endfunction

    // Drop the fraction of a full product (floor) and saturate.
    function automatic logic signed [DATA_W-1:0] qsat(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        s = p >>> FRAC_W;
        if (s > PROD_W'(Q_MAX))
            return Q_MAX;
        if (s < PROD_W'(Q_MIN))
            return Q_MIN;
        return s[DATA_W-1:0];
    endfunction

endpackage

[rtl/core/pidc_in_if.sv]
// Input channel of the PID controller: measurement, step time and mode.
// Depends on pidc_pkg for the data width.
interface pidc_in_if import pidc_pkg::*; ;
    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic signed [DATA_W-1:0] measured_value;
    logic [DATA_W-1:0]        step_time;

    modport source (output valid, mode, measured_value, step_time, input ready);
    modport sink   (input valid, mode, measured_value, step_time, output ready);
endinterface

[rtl/core/pidc_out_if.sv]
// Output channel of the PID controller: drive value and derivative bypass flag.
// Depends on pidc_pkg for the data width.
interface pidc_out_if import pidc_pkg::*; ;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] drive_value;
    logic                     deriv_skipped;

    modport source (output valid, drive_value, deriv_skipped, input ready);
    modport sink   (input valid, drive_value, deriv_skipped, output ready);
endinterface

[rtl/core/pidc_div.sv]
// Restoring serial divider, one quotient bit per cycle, unsigned operands.
// Depends on pidc_pkg for operand widths.
module pidc_div import pidc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              busy,
    output logic [DIVD_W-1:0] quotient
);

    logic [WIDE_W-1:0]    rem_reg;
    logic [DIVD_W-1:0]    quo_reg;
    logic [DATA_W-1:0]    dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;

    logic [WIDE_W-1:0]    shifted;
    logic [WIDE_W:0]      trial;
    logic                 fits;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    assign shifted = {rem_reg[DATA_W-1:0], quo_reg[DIVD_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dvs_reg};
    assign fits    = !trial[WIDE_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(DIVD_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial[WIDE_W-1:0] : shifted;
            quo_reg <= {quo_reg[DIVD_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

[rtl/core/pid_controller_clamped.sv]
// PID controller top level: config registers, step sequencer and shared multiplier.
// Depends on pidc_pkg, pidc_in_if, pidc_out_if and pidc_div.
//
//   channel   direction  handshake      payload
//   in_ch     sink       valid/ready    mode, measured_value, step_time
//   out_ch    source     valid/ready    drive_value, deriv_skipped
//   cfg       write      cfg_we         cfg_index, cfg_wdata
//
// A control step runs from input transfer to output valid; its length is set
// by the serial divider for the derivative, one quotient bit at a time. A zero
// step time skips the divider, and a clear request goes straight to the output.
// One item is in flight at a time: in_ch.ready is high only while idle.
// A stalled output holds the block until the result transfers.
// Reset loads the default gains and limits and clears the integral and last sample.
module pid_controller_clamped import pidc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    pidc_in_if.sink              in_ch,
    pidc_out_if.source           out_ch,
    input  logic                 cfg_we,
    input  cfg_idx_t             cfg_index,
    input  logic [DATA_W-1:0]    cfg_wdata
);

    typedef enum logic [3:0] {
        S_IDLE, S_ERR, S_MI, S_INT, S_MP, S_SP, S_MG, S_SG,
        S_DWAIT, S_MD, S_SD, S_CLAMP, S_OUT
    } state_t;

    state_t state_reg;

    // configuration
    logic signed [DATA_W-1:0] prop_gain_reg;
    logic signed [DATA_W-1:0] integ_gain_reg;
    logic signed [DATA_W-1:0] deriv_gain_reg;
    logic signed [DATA_W-1:0] setpoint_reg;
    logic signed [DATA_W-1:0] out_min_reg;
    logic signed [DATA_W-1:0] out_max_reg;
    logic [LIM_W-1:0]         integ_limit_reg;

    // controller state and working registers
    logic signed [DATA_W-1:0] integ_accum_reg;
    logic signed [DATA_W-1:0] last_sample_reg;
    logic signed [DATA_W-1:0] meas_reg;
    logic [DATA_W-1:0]        dt_reg;
    logic signed [DATA_W-1:0] err_reg;
    logic signed [WIDE_W-1:0] diff_reg;
    logic signed [DATA_W-1:0] integ_reg;
    logic signed [DATA_W-1:0] deriv_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [DATA_W-1:0] drive_reg;
    logic                     skipped_reg;
    logic                     out_valid_reg;

    // shared multiplier
    logic signed [WIDE_W-1:0] mul_a;
    logic signed [WIDE_W-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_prod;

    // datapath helpers
    logic signed [DATA_W-1:0] prod_q;
    logic signed [WIDE_W-1:0] integ_sum;
    logic signed [DATA_W-1:0] integ_sat;
    logic signed [WIDE_W-1:0] lim_pos;
    logic signed [WIDE_W-1:0] lim_neg;
    logic [WIDE_W-1:0]        diff_mag;
    logic signed [DATA_W-1:0] deriv_val;
    logic signed [DATA_W-1:0] drive_sat;
    logic                     in_xfer;
    logic                     out_xfer;

    // divider
    logic                     div_start;
    logic                     div_busy;
    logic [DIVD_W-1:0]        div_quot;

    assign in_xfer  = in_ch.valid && in_ch.ready;
    assign out_xfer = out_ch.valid && out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg   <= PROP_GAIN_RST;
            integ_gain_reg  <= INTEG_GAIN_RST;
            deriv_gain_reg  <= '0;
            setpoint_reg    <= '0;
            out_min_reg     <= Q_MIN;
            out_max_reg     <= Q_MAX;
            integ_limit_reg <= INTEG_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PROP_GAIN:   prop_gain_reg   <= cfg_wdata;
                REG_INTEG_GAIN:  integ_gain_reg  <= cfg_wdata;
                REG_DERIV_GAIN:  deriv_gain_reg  <= cfg_wdata;
                REG_SETPOINT:    setpoint_reg    <= cfg_wdata;
                REG_OUT_MIN:     out_min_reg     <= cfg_wdata;
                REG_OUT_MAX:     out_max_reg     <= cfg_wdata;
                REG_INTEG_LIMIT: integ_limit_reg <= cfg_wdata[LIM_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (state_reg)
            S_MI:
            begin
                mul_a = {err_reg[DATA_W-1], err_reg};
                mul_b = {1'b0, dt_reg};
            end
            S_MP:
            begin
                mul_a = {prop_gain_reg[DATA_W-1], prop_gain_reg};
                mul_b = {err_reg[DATA_W-1], err_reg};
            end
            S_MG:
            begin
                mul_a = {integ_gain_reg[DATA_W-1], integ_gain_reg};
                mul_b = {integ_reg[DATA_W-1], integ_reg};
            end
            S_MD:
            begin
                mul_a = {deriv_gain_reg[DATA_W-1], deriv_gain_reg};
                mul_b = {deriv_reg[DATA_W-1], deriv_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_prod = mul_a * mul_b;

    // register the product before it is used
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_prod;
    end

    assign prod_q    = qsat(prod_reg);
    assign integ_sum = WIDE_W'(integ_accum_reg) + WIDE_W'(prod_q);
    assign integ_sat = sat_wide(integ_sum);
    assign lim_pos   = {2'b00, integ_limit_reg};
    assign lim_neg   = -lim_pos;

    // magnitude of the sample change; quotient is negative when the sample rose
    assign diff_mag  = diff_reg[WIDE_W-1] ? (~diff_reg + 1'b1) : diff_reg;
    always_comb
    begin
        if (skipped_reg)
            deriv_val = '0;
        else if (!diff_reg[WIDE_W-1])
            deriv_val = (div_quot > DIVD_W'(Q_MAX) + 1'b1) ? Q_MIN
                      : DATA_W'(-div_quot);
        else
            deriv_val = (div_quot > DIVD_W'(Q_MAX)) ? Q_MAX : DATA_W'(div_quot);
    end

    assign drive_sat = sat_sum(sum_reg);
    assign div_start = (state_reg == S_INT) && !skipped_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            integ_accum_reg <= '0;
            last_sample_reg <= '0;
            out_valid_reg   <= 1'b0;
            drive_reg       <= '0;
            skipped_reg     <= 1'b0;
            meas_reg        <= '0;
            dt_reg          <= '0;
            err_reg         <= '0;
            diff_reg        <= '0;
            integ_reg       <= '0;
            deriv_reg       <= '0;
            sum_reg         <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        if (in_ch.mode)
                        begin
                            integ_accum_reg <= '0;
                            last_sample_reg <= '0;
                            drive_reg       <= '0;
                            skipped_reg     <= 1'b0;
                            out_valid_reg   <= 1'b1;
                            state_reg       <= S_OUT;
                        end
                        else
                        begin
                            meas_reg  <= in_ch.measured_value;
                            dt_reg    <= in_ch.step_time;
                            state_reg <= S_ERR;
                        end
                    end
                end
                S_ERR:
                begin
                    err_reg         <= sat_wide(WIDE_W'(setpoint_reg) - WIDE_W'(meas_reg));
                    diff_reg        <= WIDE_W'(meas_reg) - WIDE_W'(last_sample_reg);
                    last_sample_reg <= meas_reg;
                    skipped_reg     <= (dt_reg == '0);
                    state_reg       <= S_MI;
                end
                S_MI:
                    state_reg <= S_INT;
                S_INT:
                begin
                    // clamp the new integral to the symmetric limit
                    if (WIDE_W'(integ_sat) < lim_neg)
                    begin
                        integ_reg       <= lim_neg[DATA_W-1:0];
                        integ_accum_reg <= lim_neg[DATA_W-1:0];
                    end
                    else if (WIDE_W'(integ_sat) > lim_pos)
                    begin
                        integ_reg       <= lim_pos[DATA_W-1:0];
                        integ_accum_reg <= lim_pos[DATA_W-1:0];
                    end
                    else
                    begin
                        integ_reg       <= integ_sat;
                        integ_accum_reg <= integ_sat;
                    end
                    state_reg <= S_MP;
                end
                S_MP:
                    state_reg <= S_SP;
                S_SP:
                begin
                    sum_reg   <= SUM_W'(prod_q);
                    state_reg <= S_MG;
                end
                S_MG:
                    state_reg <= S_SG;
                S_SG:
                begin
                    sum_reg   <= sum_reg + SUM_W'(prod_q);
                    state_reg <= S_DWAIT;
                end
                S_DWAIT:
                begin
                    // hold until the quotient is complete
                    if (!div_busy)
                    begin
                        deriv_reg <= deriv_val;
                        state_reg <= S_MD;
                    end
                end
                S_MD:
                    state_reg <= S_SD;
                S_SD:
                begin
                    sum_reg   <= sum_reg + SUM_W'(prod_q);
                    state_reg <= S_CLAMP;
                end
                S_CLAMP:
                begin
                    // lower limit is checked first: with inverted limits a value below it takes it, any other the upper
                    if (drive_sat < out_min_reg)
                        drive_reg <= out_min_reg;
                    else if (drive_sat > out_max_reg)
                        drive_reg <= out_max_reg;
                    else
                        drive_reg <= drive_sat;
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_xfer)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    pidc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({diff_mag, {FRAC_W{1'b0}}}),
        .divisor  (dt_reg),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    assign in_ch.ready          = (state_reg == S_IDLE);
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.drive_value   = drive_reg;
    assign out_ch.deriv_skipped = skipped_reg;

    // one item in flight: never take input while a result waits
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !out_ch.valid)
        else $error("input ready while a result is pending");

    a_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && in_ch.mode) |=> (integ_accum_reg == '0 && last_sample_reg == '0
                                     && out_ch.valid && out_ch.drive_value == '0))
        else $error("clear request did not clear the stored state");

    a_div_idle_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_div_done_for_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !div_busy)
        else $error("result presented before the divider finished");

    a_skip_no_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DWAIT && skipped_reg) |-> !div_busy)
        else $error("divider running for a zero step time");

endmodule
